/* design/dmct_pkg.sv */
// ----------------------------------------------------------------------------
// dmct_pkg: shared definitions for the direct-mapped counting table
// Table geometry, field widths, command and outcome codes, register indexes,
// the stored entry layout and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dmct_pkg;

   // Table geometry.
   localparam int INDEX_BITS = 10;
   localparam int SLOTS      = 2 ** INDEX_BITS;

   // Field widths fixed by the interface.
   localparam int KEY_W       = 64;
   localparam int COUNT_W     = 32;
   localparam int REQ_INDEX_W = 10;
   localparam int OUTCOME_W   = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Width that holds both the request index and a table slot.
   localparam int SLOT_EXT_W = (INDEX_BITS > REQ_INDEX_W) ? INDEX_BITS : REQ_INDEX_W;

   // Count constants.
   localparam logic [COUNT_W-1:0] START_COUNT_PLAIN = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] START_COUNT_BOOST = COUNT_W'(1000);
   localparam logic [COUNT_W-1:0] THRESHOLD_RESET   = COUNT_W'(5);
   localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

   // Request commands.
   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_READ   = 1'b1
   } command_type;

   // Result outcome codes.
   typedef enum logic [OUTCOME_W-1:0] {
      OUT_NEW  = 3'd0,
      OUT_INC  = 3'd1,
      OUT_SIDE = 3'd2,
      OUT_COLL = 3'd3,
      OUT_READ = 3'd4
   } outcome_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_MODE     = 2'd0,
      REG_KEEP_THRESHOLD = 2'd1
   } csr_reg_type;

   // One table slot as stored in memory.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic               side;
      logic [COUNT_W-1:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_DECIDE = 2'd2
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_write;
      logic accept;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic out_free;
   } dp_status_type;

endpackage

/* design/direct_mapped_counting_table_core.sv */
// ----------------------------------------------------------------------------
// direct_mapped_counting_table_core: direct-mapped table of keys with counts
// Inserts a key and side into the slot given by the key's low bits, counting
// repeat occurrences, or reads back one slot by index.
//
//   channel  direction  handshake             contents
//   req_     in         req_valid/req_stall   command, key, side, index
//   rsp_     out        rsp_valid/rsp_stall   outcome, entry, keep flag
//   csr_     in         csr_write             start mode, keep threshold
//
// In each transaction the table read is issued at acceptance, and the decision
// and write-back follow once the read data is registered. One transaction is
// in flight at a time; the registered table read followed by the write-back
// of the same slot sets that figure. After reset a clearing pass zeroes every
// table slot, one slot a cycle, with no requests accepted meanwhile.
// A stalled result holds in the output register; the next transaction may be
// accepted but waits at write-back until the result register is free.
// ----------------------------------------------------------------------------
module direct_mapped_counting_table_core (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [dmct_pkg::KEY_W-1:0]        req_key,
   input  logic                              req_side,
   input  logic [dmct_pkg::REQ_INDEX_W-1:0]  req_index,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dmct_pkg::OUTCOME_W-1:0]    rsp_outcome,
   output logic [dmct_pkg::KEY_W-1:0]        rsp_entry_key,
   output logic                              rsp_entry_side,
   output logic [dmct_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic                              rsp_keep,
   // Configuration port
   input  logic                              csr_write,
   input  logic [dmct_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dmct_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dmct_pkg::dp_cmd_type    cmd;
   dmct_pkg::dp_status_type status;

   // Sequencing.
   dmct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Table, registers and result path.
   dmct_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_side        (req_side),
      .req_index       (req_index),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_outcome     (rsp_outcome),
      .rsp_entry_key   (rsp_entry_key),
      .rsp_entry_side  (rsp_entry_side),
      .rsp_entry_count (rsp_entry_count),
      .rsp_keep        (rsp_keep),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

/* design/dmct_ram.sv */
// ----------------------------------------------------------------------------
// dmct_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered and holds
// its value until the next read enable.
// ----------------------------------------------------------------------------
module dmct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/dmct_datapath.sv */
// ----------------------------------------------------------------------------
// dmct_datapath: table memory, configuration registers and result register
// Holds the table, captures the request, works out the insert outcome from
// the slot read back, writes the slot and loads the result register.
// ----------------------------------------------------------------------------
module dmct_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request payload
   input  logic                                  req_command,
   input  logic [dmct_pkg::KEY_W-1:0]            req_key,
   input  logic                                  req_side,
   input  logic [dmct_pkg::REQ_INDEX_W-1:0]      req_index,
   // Configuration port
   input  logic                                  csr_write,
   input  logic [dmct_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dmct_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // Result channel
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [dmct_pkg::OUTCOME_W-1:0]        rsp_outcome,
   output logic [dmct_pkg::KEY_W-1:0]            rsp_entry_key,
   output logic                                  rsp_entry_side,
   output logic [dmct_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic                                  rsp_keep,
   // Controller interface
   input  dmct_pkg::dp_cmd_type                  cmd,
   output dmct_pkg::dp_status_type               status
);

   // Configuration registers.
   logic                            start_mode_ff, start_mode_in;
   logic [dmct_pkg::COUNT_W-1:0]    keep_threshold_ff, keep_threshold_in;

   // Clearing pass address.
   logic [dmct_pkg::INDEX_BITS-1:0] clr_addr_ff, clr_addr_in;

   // Captured request.
   logic                            cap_command_ff;
   logic [dmct_pkg::KEY_W-1:0]      cap_key_ff;
   logic                            cap_side_ff;
   logic [dmct_pkg::INDEX_BITS-1:0] cap_slot_ff;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dmct_pkg::OUTCOME_W-1:0]  rsp_outcome_ff;
   dmct_pkg::entry_type             rsp_entry_ff;

   // Memory interface.
   logic                            ram_wr_en;
   logic [dmct_pkg::INDEX_BITS-1:0] ram_wr_addr;
   dmct_pkg::entry_type             ram_wr_data;
   dmct_pkg::entry_type             ram_rd_data;

   // Request slot and decision logic.
   logic [dmct_pkg::SLOT_EXT_W-1:0] req_index_ext;
   logic [dmct_pkg::INDEX_BITS-1:0] req_slot;
   dmct_pkg::entry_type             new_entry;
   logic [dmct_pkg::OUTCOME_W-1:0]  outcome;
   logic                            write_needed;
   logic [dmct_pkg::COUNT_W-1:0]    count_inc;

   // Configuration register writes; unknown indexes are ignored.
   always_comb begin
      start_mode_in     = start_mode_ff;
      keep_threshold_in = keep_threshold_ff;
      if (csr_write) begin
         case (csr_index)
            dmct_pkg::REG_START_MODE: begin
               start_mode_in = csr_wdata[0];
            end
            dmct_pkg::REG_KEEP_THRESHOLD: begin
               keep_threshold_in = csr_wdata[dmct_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clearing pass walks every slot once after reset.
   assign clr_addr_in     = cmd.clr_write ? clr_addr_ff + 1'b1 : clr_addr_ff;
   assign status.clr_last = &clr_addr_ff;

   // Slot addressed by the incoming request.
   assign req_index_ext = dmct_pkg::SLOT_EXT_W'(req_index);
   assign req_slot      = (req_command == dmct_pkg::CMD_READ)
                          ? req_index_ext[dmct_pkg::INDEX_BITS-1:0]
                          : req_key[dmct_pkg::INDEX_BITS-1:0];

   // Insert decision on the slot read back; a read keeps the slot as it is.
   always_comb begin
      count_inc    = (ram_rd_data.count == dmct_pkg::COUNT_MAX)
                     ? ram_rd_data.count : ram_rd_data.count + 1'b1;
      new_entry    = ram_rd_data;
      write_needed = 1'b0;
      if (cap_command_ff == dmct_pkg::CMD_READ) begin
         outcome = dmct_pkg::OUT_READ;
      end else if (ram_rd_data.key == '0) begin
         outcome         = dmct_pkg::OUT_NEW;
         new_entry.key   = cap_key_ff;
         new_entry.side  = cap_side_ff;
         new_entry.count = start_mode_ff ? dmct_pkg::START_COUNT_BOOST
                                         : dmct_pkg::START_COUNT_PLAIN;
         write_needed    = 1'b1;
      end else if (ram_rd_data.key == cap_key_ff) begin
         if (ram_rd_data.side == cap_side_ff) begin
            outcome         = dmct_pkg::OUT_INC;
            new_entry.count = count_inc;
            write_needed    = 1'b1;
         end else begin
            outcome = dmct_pkg::OUT_SIDE;
         end
      end else begin
         outcome = dmct_pkg::OUT_COLL;
      end
   end

   // Memory write: zeroes during the clearing pass, else the updated slot.
   assign ram_wr_en   = cmd.clr_write | (cmd.commit & write_needed);
   assign ram_wr_addr = cmd.clr_write ? clr_addr_ff : cap_slot_ff;
   assign ram_wr_data = cmd.clr_write ? '0 : new_entry;

   dmct_ram #(
      .WIDTH (dmct_pkg::ENTRY_W),
      .DEPTH (dmct_pkg::SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (req_slot),
      .rd_data (ram_rd_data)
   );

   // Result register may be loaded when empty or being taken.
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in    = cmd.commit | (rsp_valid_ff & rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_mode_ff     <= 1'b0;
         keep_threshold_ff <= dmct_pkg::THRESHOLD_RESET;
         clr_addr_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         start_mode_ff     <= start_mode_in;
         keep_threshold_ff <= keep_threshold_in;
         clr_addr_ff       <= clr_addr_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers: captured request and result.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cap_command_ff <= req_command;
         cap_key_ff     <= req_key;
         cap_side_ff    <= req_side;
         cap_slot_ff    <= req_slot;
      end
      if (cmd.commit) begin
         rsp_outcome_ff <= outcome;
         rsp_entry_ff   <= new_entry;
      end
   end

   // Result ports; keep follows from the registered entry and threshold.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_entry_key   = rsp_entry_ff.key;
   assign rsp_entry_side  = rsp_entry_ff.side;
   assign rsp_entry_count = rsp_entry_ff.count;
   assign rsp_keep        = (rsp_entry_ff.key != '0) && (rsp_entry_ff.count > keep_threshold_ff);

   // The result register is loaded only by a commit.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result became valid without a commit");

   // A commit never overwrites a result that is still held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("commit overwrote a stalled result");

   // An incremented entry always carries a nonzero count.
   a_inc_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_outcome_ff == dmct_pkg::OUT_INC) |-> (rsp_entry_ff.count != '0))
      else $error("incremented entry has a zero count");

endmodule

/* design/dmct_ctrl.sv */
// ----------------------------------------------------------------------------
// dmct_ctrl: sequencing for the counting table
// Runs the clearing pass after reset, then takes one request at a time:
// memory read at acceptance, decision and write-back in the next state.
// ----------------------------------------------------------------------------
module dmct_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output dmct_pkg::dp_cmd_type     cmd,
   input  dmct_pkg::dp_status_type  status
);

   dmct_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmct_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         dmct_pkg::ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = dmct_pkg::ST_IDLE;
            end
         end
         dmct_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = dmct_pkg::ST_DECIDE;
            end
         end
         dmct_pkg::ST_DECIDE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = dmct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmct_pkg::ST_CLEAR;
         end
      endcase
   end

   // Once the clearing pass is over it does not start again.
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != dmct_pkg::ST_CLEAR) |=> (state_ff != dmct_pkg::ST_CLEAR))
      else $error("clearing pass restarted without reset");

   // An accepted transaction reaches the decision state in the following cycle.
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == dmct_pkg::ST_DECIDE))
      else $error("accepted transaction did not reach the decision state");

endmodule

/* dv/tb_direct_mapped_counting_table_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_counting_table_core: self-checking bench for the table core
// Sends insert and read transactions through the request channel and keeps a
// private copy of the table, which predicts the slot report for each accepted
// transaction. Reports are checked in order, field by field. The run moves
// through several start-mode and keep-threshold settings with random gaps on
// one or both channels, ending with a stretch that has no gaps at all.
// ----------------------------------------------------------------------------
module tb_direct_mapped_counting_table_core;

   localparam int CLOCK_HIGH    = 6;
   localparam int CLOCK_LOW     = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT  = 10;
   localparam int GAP_MAX       = 13;
   localparam int POOL_SLOTS    = 4;
   localparam int KEYS_PER_SLOT = 3;
   localparam int POOL_SIZE     = POOL_SLOTS * KEYS_PER_SLOT;
   localparam int OUTCOME_KINDS = int'(dmct_pkg::OUT_READ) + 1;

   // Register indexes that decode to nothing in the block.
   localparam logic [dmct_pkg::CSR_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [dmct_pkg::CSR_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

   // One slot report as carried by the result channel.
   typedef struct {
      dmct_pkg::outcome_type        outcome;
      logic [dmct_pkg::KEY_W-1:0]   key;
      logic                         side;
      logic [dmct_pkg::COUNT_W-1:0] count;
      logic                         keep;
   } slot_report_type;

   // Private copy of the table and registers, plus the reports still owed.
   class count_table_book;
      logic [dmct_pkg::KEY_W-1:0]   held_key   [dmct_pkg::SLOTS];
      logic                         held_side  [dmct_pkg::SLOTS];
      logic [dmct_pkg::COUNT_W-1:0] held_count [dmct_pkg::SLOTS];
      logic                         boost_start;
      logic [dmct_pkg::COUNT_W-1:0] keep_limit;
      slot_report_type              owed_reports [$];
      int                           faults;
      int                           reports_checked;
      int                           outcome_tally [OUTCOME_KINDS];

      function new();
         foreach (held_key[i]) begin
            held_key[i]   = '0;
            held_side[i]  = 1'b0;
            held_count[i] = '0;
         end
         boost_start     = 1'b0;
         keep_limit      = dmct_pkg::THRESHOLD_RESET;
         faults          = 0;
         reports_checked = 0;
         foreach (outcome_tally[i]) outcome_tally[i] = 0;
      endfunction

      // A register write; spare indexes change nothing.
      function void note_register(logic [dmct_pkg::CSR_INDEX_W-1:0] reg_index,
                                  logic [dmct_pkg::CSR_DATA_W-1:0] value);
         case (reg_index)
            dmct_pkg::REG_START_MODE:     boost_start = value[0];
            dmct_pkg::REG_KEEP_THRESHOLD: keep_limit  = value[dmct_pkg::COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Apply an accepted transaction to the table copy and queue its report.
      function void note_request(dmct_pkg::command_type command,
                                 logic [dmct_pkg::KEY_W-1:0] key, logic side,
                                 logic [dmct_pkg::REQ_INDEX_W-1:0] index);
         int              slot;
         slot_report_type report;
         if (command == dmct_pkg::CMD_READ) begin
            slot           = int'(index) % dmct_pkg::SLOTS;
            report.outcome = dmct_pkg::OUT_READ;
         end else begin
            slot = int'(key[dmct_pkg::INDEX_BITS-1:0]);
            if (held_key[slot] == '0) begin
               // An empty slot takes the key, even a zero key.
               held_key[slot]   = key;
               held_side[slot]  = side;
               held_count[slot] = boost_start ? dmct_pkg::START_COUNT_BOOST
                                              : dmct_pkg::START_COUNT_PLAIN;
               report.outcome   = dmct_pkg::OUT_NEW;
            end else if (held_key[slot] != key) begin
               report.outcome = dmct_pkg::OUT_COLL;
            end else if (held_side[slot] != side) begin
               report.outcome = dmct_pkg::OUT_SIDE;
            end else begin
               // The count sticks at its maximum.
               if (held_count[slot] != dmct_pkg::COUNT_MAX) held_count[slot] += 1;
               report.outcome = dmct_pkg::OUT_INC;
            end
         end
         report.key   = held_key[slot];
         report.side  = held_side[slot];
         report.count = held_count[slot];
         report.keep  = (held_key[slot] != '0) && (held_count[slot] > keep_limit);
         owed_reports.push_back(report);
      endfunction

      // Compare a delivered report with the oldest one owed.
      function void check_result(slot_report_type seen);
         slot_report_type want;
         if (owed_reports.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("ERROR: unexpected result: outcome %0d key %h side %b count %0d keep %b",
                        seen.outcome, seen.key, seen.side, seen.count, seen.keep);
            return;
         end
         want = owed_reports.pop_front();
         reports_checked++;
         outcome_tally[int'(want.outcome)]++;
         if (seen.outcome !== want.outcome || seen.key !== want.key ||
             seen.side !== want.side || seen.count !== want.count ||
             seen.keep !== want.keep) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
               $display("ERROR: transaction %0d: expected outcome %0d key %h side %b count %0d keep %b",
                        reports_checked, want.outcome, want.key, want.side, want.count,
                        want.keep);
               $display("       received outcome %0d key %h side %b count %0d keep %b",
                        seen.outcome, seen.key, seen.side, seen.count, seen.keep);
            end
         end
      endfunction
   endclass

   logic                             clock           = 1'b0;
   logic                             reset           = 1'b1;
   logic                             req_valid       = 1'b0;
   logic                             req_stall;
   logic                             req_command     = 1'b0;
   logic [dmct_pkg::KEY_W-1:0]       req_key         = '0;
   logic                             req_side        = 1'b0;
   logic [dmct_pkg::REQ_INDEX_W-1:0] req_index       = '0;
   logic                             rsp_valid;
   logic                             rsp_stall       = 1'b0;
   logic [dmct_pkg::OUTCOME_W-1:0]   rsp_outcome;
   logic [dmct_pkg::KEY_W-1:0]       rsp_entry_key;
   logic                             rsp_entry_side;
   logic [dmct_pkg::COUNT_W-1:0]     rsp_entry_count;
   logic                             rsp_keep;
   logic                             csr_write       = 1'b0;
   logic [dmct_pkg::CSR_INDEX_W-1:0] csr_index       = '0;
   logic [dmct_pkg::CSR_DATA_W-1:0]  csr_wdata       = '0;

   count_table_book book = new();
   int              send_odds        = 6;
   int              stall_odds       = 8;
   int              quiet_cycles     = 0;
   int              settings_applied = 0;

   direct_mapped_counting_table_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_side        (req_side),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_outcome     (rsp_outcome),
      .rsp_entry_key   (rsp_entry_key),
      .rsp_entry_side  (rsp_entry_side),
      .rsp_entry_count (rsp_entry_count),
      .rsp_keep        (rsp_keep),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Clock generation.
   always begin
      #(CLOCK_LOW) clock = 1'b1;
      #(CLOCK_HIGH) clock = 1'b0;
   end

   // Observe both channels and the register port at each rising edge.
   always @(posedge clock) begin : observe
      slot_report_type seen;
      if (!reset) begin
         if (csr_write) book.note_register(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            book.note_request(dmct_pkg::command_type'(req_command), req_key, req_side,
                              req_index);
         if (rsp_valid && !rsp_stall) begin
            seen.outcome = dmct_pkg::outcome_type'(rsp_outcome);
            seen.key     = rsp_entry_key;
            seen.side    = rsp_entry_side;
            seen.count   = rsp_entry_count;
            seen.keep    = rsp_keep;
            book.check_result(seen);
         end
      end
   end

   // Watchdog: the run is abandoned when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ERROR: no transaction for %0d cycles", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side back-pressure in random bursts.
   always begin : receiver_pacing
      @(posedge clock);
      if (!reset && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, GAP_MAX)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Present one transaction, possibly after a gap, and hold it until taken.
   task automatic send_request(dmct_pkg::command_type command,
                               logic [dmct_pkg::KEY_W-1:0] key, logic side,
                               logic [dmct_pkg::REQ_INDEX_W-1:0] index);
      if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, GAP_MAX)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= command;
      req_key     <= key;
      req_side    <= side;
      req_index   <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait until every owed report has been delivered.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.owed_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers, and the spare indexes when asked, back to back.
   task automatic program_registers(logic [dmct_pkg::CSR_DATA_W-1:0] mode_word,
                                    logic [dmct_pkg::CSR_DATA_W-1:0] threshold,
                                    bit touch_spares);
      csr_write <= 1'b1;
      csr_index <= dmct_pkg::REG_START_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      if (touch_spares) begin
         csr_index <= REG_SPARE_LO;
         csr_wdata <= $urandom;
         @(posedge clock);
         csr_index <= REG_SPARE_HI;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_index <= dmct_pkg::REG_KEEP_THRESHOLD;
      csr_wdata <= threshold;
      @(posedge clock);
      csr_write <= 1'b0;
      settings_applied++;
   endtask

   // Hand-picked transactions under the reset settings.
   task automatic run_directed();
      // A zero key always lands in an empty slot, twice over.
      send_request(dmct_pkg::CMD_INSERT, 64'h0, 1'b1, 10'h3FF);
      send_request(dmct_pkg::CMD_INSERT, 64'h0, 1'b0, 10'h000);
      send_request(dmct_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 10'h000);
      // New entry, repeat, side mismatch and collision on the top slot.
      send_request(dmct_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 10'h000);
      send_request(dmct_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 10'h2AA);
      send_request(dmct_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 10'h155);
      send_request(dmct_pkg::CMD_INSERT, 64'h8000_0000_0000_03FF, 1'b1, 10'h3FF);
      send_request(dmct_pkg::CMD_READ, 64'h0, 1'b0, 10'h3FF);
      // Count one key past the keep threshold.
      repeat (7) send_request(dmct_pkg::CMD_INSERT, 64'h5, 1'b0, 10'h000);
      send_request(dmct_pkg::CMD_READ, 64'h0, 1'b0, 10'h005);
      // Alternating bit patterns in key and index.
      send_request(dmct_pkg::CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 10'h155);
      send_request(dmct_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 1'b0, 10'h2AA);
      send_request(dmct_pkg::CMD_READ, 64'h5555_5555_5555_5555, 1'b0, 10'h2AA);
      send_request(dmct_pkg::CMD_READ, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 10'h155);
      // A slot that was never written reads back as cleared.
      send_request(dmct_pkg::CMD_READ, 64'h0, 1'b0, 10'h200);
      // A slot holding a zero key counts as empty.
      send_request(dmct_pkg::CMD_INSERT, 64'h400, 1'b1, 10'h000);
      send_request(dmct_pkg::CMD_INSERT, 64'h400, 1'b1, 10'h000);
   endtask

   // One register setting followed by random traffic around a small key pool.
   task automatic run_phase(bit boost, logic [dmct_pkg::COUNT_W-1:0] threshold, int items,
                            bit touch_spares, int send_gap, int stall_gap);
      logic [dmct_pkg::KEY_W-1:0]       pool_key  [POOL_SIZE];
      logic                             pool_side [POOL_SIZE];
      logic [dmct_pkg::INDEX_BITS-1:0]  pool_slot [POOL_SLOTS];
      logic [dmct_pkg::CSR_DATA_W-1:0]  mode_word;
      logic [dmct_pkg::KEY_W-1:0]       key;
      logic                             side;
      logic [dmct_pkg::REQ_INDEX_W-1:0] index;
      int                               pick;
      int                               roll;
      drain_results();
      send_odds  = send_gap;
      stall_odds = stall_gap;
      // Upper bits of the mode word must be ignored.
      mode_word    = $urandom;
      mode_word[0] = boost;
      program_registers(mode_word, threshold, touch_spares);

      // Several keys share each pool slot, so collisions come naturally.
      foreach (pool_slot[s])
         pool_slot[s] = dmct_pkg::INDEX_BITS'($urandom_range(0, dmct_pkg::SLOTS - 1));
      foreach (pool_key[p]) begin
         pool_key[p] = {$urandom, $urandom};
         if ($urandom_range(0, 3) == 0) pool_key[p][dmct_pkg::KEY_W-1:32] = '0;
         pool_key[p][dmct_pkg::INDEX_BITS-1:0] = pool_slot[p % POOL_SLOTS];
         pool_side[p] = 1'($urandom_range(0, 1));
      end

      repeat (items) begin
         roll  = $urandom_range(0, 99);
         pick  = $urandom_range(0, POOL_SIZE - 1);
         key   = {$urandom, $urandom};
         side  = 1'($urandom_range(0, 1));
         index = dmct_pkg::REQ_INDEX_W'($urandom_range(0, 2 ** dmct_pkg::REQ_INDEX_W - 1));
         if (roll < 25) begin
            // Reads mostly look at the busy slots.
            if (roll < 18) index = pool_slot[pick % POOL_SLOTS];
            send_request(dmct_pkg::CMD_READ, key, side, index);
         end else if (roll < 88) begin
            // Pool key, now and then on the other side.
            side = ($urandom_range(0, 6) == 0) ? !pool_side[pick] : pool_side[pick];
            send_request(dmct_pkg::CMD_INSERT, pool_key[pick], side, index);
         end else if (roll < 93) begin
            send_request(dmct_pkg::CMD_INSERT, key, side, index);
         end else if (roll < 95) begin
            send_request(dmct_pkg::CMD_INSERT, '0, side, index);
         end else begin
            // A stranger aimed at a busy slot.
            key[dmct_pkg::INDEX_BITS-1:0] = pool_slot[pick % POOL_SLOTS];
            send_request(dmct_pkg::CMD_INSERT, key, side, index);
         end
      end
   endtask

   // Main sequence.
   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_phase(1'b1, 32'h0000_0000, 260, 1'b0, 4, 3);
      run_phase(1'b0, 32'hFFFF_FFFF, 260, 1'b1, 10, 12);
      run_phase(1'b1, 32'd1000, 260, 1'b0, 0, 6);
      run_phase(1'b0, 32'd1, 260, 1'b1, 5, 0);
      run_phase(1'b1, $urandom, 250, 1'b0, 8, 8);
      // Final stretch at full rate on both sides.
      run_phase(1'b0, dmct_pkg::THRESHOLD_RESET, 250, 1'b0, 0, 0);
      drain_results();

      if (book.owed_reports.size() != 0) book.faults += book.owed_reports.size();
      $display("Checked %0d transactions: %0d new, %0d increments, %0d side mismatches,",
               book.reports_checked, book.outcome_tally[int'(dmct_pkg::OUT_NEW)],
               book.outcome_tally[int'(dmct_pkg::OUT_INC)],
               book.outcome_tally[int'(dmct_pkg::OUT_SIDE)]);
      $display("%0d collisions, %0d reads, over %0d register settings; %0d failures.",
               book.outcome_tally[int'(dmct_pkg::OUT_COLL)],
               book.outcome_tally[int'(dmct_pkg::OUT_READ)],
               settings_applied, book.faults);
      if (book.faults == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
